// ===== sv/bdsm_pkg.sv =====
// ----------------------------------------------------------------------------
// bdsm_pkg
// Shared constants, tables and mixing functions of the byte driven state mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package bdsm_pkg;

	localparam int unsigned FOLD_PERIOD = 64;
	localparam int unsigned BOARD_SLOTS = 64;
	localparam int unsigned FOLD_W      = (FOLD_PERIOD > 1) ? $clog2(FOLD_PERIOD) : 1;
	localparam int unsigned FOLD_ROUNDS = 7;

	localparam logic [63:0] DELTA_CONST  = 64'h1D1D_1D1D_1D1D_1D1D;
	localparam logic [13:0] BRAILLE_BASE = 14'h2800;

	// register map, 8 byte stride
	localparam int unsigned ADDR_W = 5;
	typedef enum logic [1:0] {
		REG_RULE_SEL      = 2'd0,
		REG_START_SEED    = 2'd1,
		REG_BASE_CONSTANT = 2'd2,
		REG_NONE          = 2'd3
	} reg_idx_t;

	typedef logic [2:0] fano_line_t [3];
	localparam fano_line_t FANO_TAB [7] = '{
		'{3'd0, 3'd1, 3'd3}, '{3'd0, 3'd2, 3'd5}, '{3'd0, 3'd4, 3'd6},
		'{3'd1, 3'd2, 3'd4}, '{3'd1, 3'd5, 3'd6}, '{3'd2, 3'd3, 3'd6},
		'{3'd3, 3'd4, 3'd5}
	};

	function automatic logic [7:0] mix8(input logic [7:0] s, input logic [7:0] c);
		return {s[6:0], s[7]} ^ {s[4:0], s[7:5]} ^ {s[1:0], s[7:2]} ^ c;
	endfunction

	function automatic logic [63:0] mix64(input logic [63:0] s);
		return {s[62:0], s[63]} ^ {s[60:0], s[63:61]} ^ {s[1:0], s[63:2]} ^ DELTA_CONST;
	endfunction

	// 8-bit rule: law bits, projection bits and boundary bit
	function automatic logic [7:0] rule_one(input logic [7:0] s, input logic [7:0] in_b,
		input logic [2:0] b7, input logic [2:0] b8);
		logic [7:0] law;
		logic [7:0] proj;
		law  = (s ^ {in_b[6:0], 1'b0}) & 8'h03;
		proj = ({s[6:0], s[7]} ^ in_b ^ {5'd0, b7} ^ {3'd0, b8, 2'b00}) & 8'h0C;
		if (in_b == 8'd0) begin
			return 8'd0;
		end
		return law | proj | (in_b & 8'h80);
	endfunction

	// bring an offset below 2*BOARD_SLOTS into slot range
	function automatic logic [6:0] slot_off(input logic [6:0] v);
		return (v >= 7'(BOARD_SLOTS)) ? v - 7'(BOARD_SLOTS) : v;
	endfunction

	function automatic logic [BOARD_SLOTS-1:0] board_rot(input logic [BOARD_SLOTS-1:0] d,
		input logic [6:0] off);
		logic [2*BOARD_SLOTS-1:0] dd;
		dd = {d, d} << off;
		return dd[2*BOARD_SLOTS-1:BOARD_SLOTS];
	endfunction

endpackage

`default_nettype wire

// ===== sv/byte_driven_state_mixer_core.sv =====
// ----------------------------------------------------------------------------
// byte_driven_state_mixer_core
// One byte per request drives a 64-bit state and tick; every request yields a
// result describing the step.
// ----------------------------------------------------------------------------
//  channel   | signals                          | request
//  req       | req_valid / req_stall            | input_byte
//  res       | res_valid / res_stall            | tick, states, basis, law, board
//  apb       | psel penable pwrite paddr pwdata | rule select, start_seed, base
//
//  one request per cycle while res_stall is low; results pass input and result registers
//  the state update and the seven fold rounds are one xor network per cycle
//  an input register and a result register give two requests of buffering
//  req_stall rises when both registers hold requests and res_stall is high
//  reset and every write to a mapped register reload the state and clear the tick
//  tick residues mod 7, mod 15 and fold phase are kept as counters
`default_nettype none

module byte_driven_state_mixer_core
	import bdsm_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic [7:0]         input_byte,
	output logic                    res_valid,
	input  wire logic               res_stall,
	output logic [63:0]             tick_value,
	output logic [63:0]             old_state,
	output logic [63:0]             new_state,
	output logic [2:0]              basis_seven,
	output logic [2:0]              basis_eight,
	output logic [1:0]              law_bits,
	output logic [3:0]              edit_bits,
	output logic                    boundary,
	output logic [2:0]              winner,
	output logic [13:0]             braille_code,
	output logic [63:0]             board_bits,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [ADDR_W-1:0]  paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready
);

	logic        rule_q;
	logic [63:0] seed_q;
	logic [63:0] base_q;
	logic [63:0] state_q;
	logic [63:0] tick_q;
	logic [2:0]  mod7_q;
	logic        week_q;
	logic [3:0]  mod15_q;
	logic [FOLD_W-1:0] phase_q;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        valid_s2;

	logic        accept;
	logic        adv;
	logic        fire;
	logic        cfg_wr;
	reg_idx_t    reg_idx;

	logic [63:0] next_state;
	logic [2:0]  win_c;
	logic [63:0] board_c;
	logic        fold;
	logic        tick_wrap;

	assign pready    = 1'b1;
	assign reg_idx   = reg_idx_t'(paddr[4:3]);
	assign cfg_wr    = psel & penable & pwrite & pready;
	assign adv       = ~valid_s2 | ~res_stall;
	assign fire      = valid_s1 & adv;
	assign req_stall = valid_s1 & ~adv;
	assign accept    = req_valid & ~req_stall;
	assign fold      = (phase_q == '0) && (tick_q != 64'd0);
	assign tick_wrap = &tick_q;

	always_comb begin
		unique case (reg_idx)
			REG_RULE_SEL:      prdata = {63'd0, rule_q};
			REG_START_SEED:    prdata = seed_q;
			REG_BASE_CONSTANT: prdata = base_q;
			default:           prdata = 64'd0;
		endcase
	end

	// state transform with optional fold rounds
	always_comb begin
		logic [63:0] w64;
		logic [7:0]  w8;
		logic [BOARD_SLOTS-1:0] bd;
		logic [6:0]  off;
		w64 = mix64(state_q ^ {56'd0, byte_s1});
		w8  = rule_one(state_q[7:0], byte_s1, mod7_q, tick_q[2:0]);
		for (int r = 0; r < FOLD_ROUNDS; r++) begin
			if (fold) begin
				w64 = mix64(w64);
				w8  = mix8(w8, base_q[7:0]);
			end
		end
		if (rule_q) begin
			next_state = w64;
			win_c      = {2'd0, w64[tick_q[5:0]]};
			off        = slot_off({1'b0, mod15_q, 2'b00} + {3'd0, w64[3:0]});
			bd         = board_rot(BOARD_SLOTS'(w64[59:0]), off);
		end else begin
			next_state = {56'd0, w8};
			win_c      = week_q ? FANO_TAB[mod7_q][2] : FANO_TAB[mod7_q][0];
			off        = slot_off({1'b0, mod7_q, 3'b000} + {4'd0, w8[2:0]});
			bd         = board_rot(BOARD_SLOTS'(w8), off);
		end
		board_c = 64'(bd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_q   <= 1'b0;
			seed_q   <= 64'd0;
			base_q   <= 64'd0;
			state_q  <= 64'd0;
			tick_q   <= 64'd0;
			mod7_q   <= 3'd0;
			week_q   <= 1'b0;
			mod15_q  <= 4'd0;
			phase_q  <= '0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (fire) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
			if (cfg_wr && reg_idx != REG_NONE) begin
				unique case (reg_idx)
					REG_RULE_SEL:      rule_q <= pwdata[0];
					REG_START_SEED:    seed_q <= pwdata;
					REG_BASE_CONSTANT: base_q <= pwdata;
					default:           rule_q <= rule_q;
				endcase
				// reload uses the value being written
				if (reg_idx == REG_RULE_SEL) begin
					state_q <= pwdata[0] ? seed_q : base_q;
				end else if (reg_idx == REG_START_SEED) begin
					state_q <= rule_q ? pwdata : base_q;
				end else begin
					state_q <= rule_q ? seed_q : pwdata;
				end
				tick_q  <= 64'd0;
				mod7_q  <= 3'd0;
				week_q  <= 1'b0;
				mod15_q <= 4'd0;
				phase_q <= '0;
			end else if (fire) begin
				state_q <= next_state;
				tick_q  <= tick_q + 64'd1;
				if (tick_wrap) begin
					mod7_q  <= 3'd0;
					week_q  <= 1'b0;
					mod15_q <= 4'd0;
					phase_q <= '0;
				end else begin
					mod7_q  <= (mod7_q == 3'd6) ? 3'd0 : mod7_q + 3'd1;
					week_q  <= week_q ^ (mod7_q == 3'd6);
					mod15_q <= (mod15_q == 4'd14) ? 4'd0 : mod15_q + 4'd1;
					phase_q <= (phase_q == FOLD_W'(FOLD_PERIOD - 1)) ? '0 :
						phase_q + FOLD_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= input_byte;
		end
	end

	logic [63:0] tick_s2;
	logic [63:0] prev_s2;
	logic [63:0] curr_s2;
	logic [2:0]  b7_s2;
	logic [2:0]  win_s2;
	logic [63:0] board_s2;

	always_ff @(posedge clk) begin
		if (fire) begin
			tick_s2  <= tick_q;
			prev_s2  <= state_q;
			curr_s2  <= next_state;
			b7_s2    <= mod7_q;
			win_s2   <= win_c;
			board_s2 <= board_c;
		end
	end

	assign res_valid    = valid_s2;
	assign tick_value   = tick_s2;
	assign old_state    = prev_s2;
	assign new_state    = curr_s2;
	assign basis_seven  = b7_s2;
	assign basis_eight  = tick_s2[2:0];
	assign law_bits     = curr_s2[1:0];
	assign edit_bits    = {curr_s2[3:2], 2'b00};
	assign boundary     = curr_s2[7];
	assign winner       = win_s2;
	assign braille_code = BRAILLE_BASE + {6'd0, curr_s2[7:0]};
	assign board_bits   = board_s2;

endmodule

`default_nettype wire

// ===== sv/bdsm_checker.sv =====
// ----------------------------------------------------------------------------
// bdsm_checker
// Port level checks of the byte driven state mixer, bound to the core module.
// ----------------------------------------------------------------------------
`default_nettype none

module bdsm_props
	import bdsm_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               req_valid,
	input wire logic               req_stall,
	input wire logic [7:0]         input_byte,
	input wire logic               res_valid,
	input wire logic               res_stall,
	input wire logic [63:0]        tick_value,
	input wire logic [63:0]        old_state,
	input wire logic [63:0]        new_state,
	input wire logic [2:0]         basis_seven,
	input wire logic [2:0]         basis_eight,
	input wire logic [1:0]         law_bits,
	input wire logic [3:0]         edit_bits,
	input wire logic               boundary,
	input wire logic [2:0]         winner,
	input wire logic [13:0]        braille_code,
	input wire logic [63:0]        board_bits,
	input wire logic               psel,
	input wire logic               penable,
	input wire logic               pwrite,
	input wire logic [ADDR_W-1:0]  paddr,
	input wire logic [63:0]        pwdata,
	input wire logic [63:0]        prdata,
	input wire logic               pready
);

	// a stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(new_state) && $stable(tick_value))
		else $error("stalled result changed");

	// derived byte fields agree with the new state
	a_byte_fields: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> law_bits == new_state[1:0] && edit_bits == {new_state[3:2], 2'b00}
			&& boundary == new_state[7]
			&& braille_code == BRAILLE_BASE + {6'd0, new_state[7:0]})
		else $error("byte fields disagree with state");

	a_basis: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> basis_eight == tick_value[2:0] && basis_seven != 3'd7)
		else $error("basis counters wrong");

	// rule one only ever keeps the low byte and its board stays sparse
	a_rule_one: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && new_state[63:8] == 56'd0 && old_state[63:8] == 56'd0
			&& winner > 3'd1 |-> $countones(board_bits) <= 8)
		else $error("rule one board too dense");

endmodule

bind byte_driven_state_mixer_core bdsm_props u_bdsm_props (.*);

`default_nettype wire

// ===== tb/bdsm_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdsm_checker
// Watches the request, result and register channels of the state mixer,
// keeps its own copy of state, tick and registers, predicts every step and
// compares each accepted result field by field against the oldest prediction.
// ----------------------------------------------------------------------------

module bdsm_checker
	import bdsm_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	input  logic               req_stall,
	input  logic [7:0]         input_byte,
	input  logic               res_valid,
	input  logic               res_stall,
	input  logic [63:0]        tick_value,
	input  logic [63:0]        old_state,
	input  logic [63:0]        new_state,
	input  logic [2:0]         basis_seven,
	input  logic [2:0]         basis_eight,
	input  logic [1:0]         law_bits,
	input  logic [3:0]         edit_bits,
	input  logic               boundary,
	input  logic [2:0]         winner,
	input  logic [13:0]        braille_code,
	input  logic [63:0]        board_bits,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [ADDR_W-1:0]  paddr,
	input  logic [63:0]        pwdata,
	input  logic               pready,
	output int unsigned        mismatch_count,
	output int unsigned        steps_pending
);

	typedef struct packed {
		logic [63:0] tick;
		logic [63:0] prev;
		logic [63:0] curr;
		logic [2:0]  mod7;
		logic [2:0]  mod8;
		logic [1:0]  law;
		logic [3:0]  edit;
		logic        bnd;
		logic [2:0]  win;
		logic [13:0] braille;
		logic [63:0] board;
	} step_result_t;

	// first and third point of each Fano line
	localparam logic [2:0] LINE_FIRST [7] = '{3'd0, 3'd0, 3'd0, 3'd1, 3'd1, 3'd2, 3'd3};
	localparam logic [2:0] LINE_THIRD [7] = '{3'd3, 3'd5, 3'd6, 3'd4, 3'd6, 3'd6, 3'd5};

	logic        rule_sel;
	logic [63:0] seed_reg;
	logic [63:0] base_reg;
	logic [63:0] mix_state;
	logic [63:0] mix_tick;

	step_result_t pending_steps [$];
	step_result_t want;
	step_result_t got;

	function automatic logic [7:0] rotl8(input logic [7:0] v, input int k);
		return (v << k) | (v >> (8 - k));
	endfunction

	function automatic logic [63:0] rotl64(input logic [63:0] v, input int k);
		return (v << k) | (v >> (64 - k));
	endfunction

	function automatic logic [7:0] round8(input logic [7:0] s, input logic [7:0] c);
		return rotl8(s, 1) ^ rotl8(s, 3) ^ rotl8(s, 6) ^ c;
	endfunction

	function automatic logic [63:0] round64(input logic [63:0] s);
		return rotl64(s, 1) ^ rotl64(s, 3) ^ rotl64(s, 62) ^ DELTA_CONST;
	endfunction

	function automatic step_result_t mix_byte(input logic [7:0] b);
		step_result_t r;
		logic [63:0] nxt;
		logic [7:0] s;
		logic [7:0] v;
		logic [7:0] law;
		logic [7:0] proj;
		logic [7:0] s8;
		logic [2:0] b7;
		logic [2:0] b8;
		logic folding;
		int off;
		b7 = 3'(mix_tick % 7);
		b8 = mix_tick[2:0];
		folding = (mix_tick != 0) && ((mix_tick % FOLD_PERIOD) == 0);
		if (rule_sel) begin
			nxt = round64(mix_state ^ {56'd0, b});
			if (folding) begin
				repeat (FOLD_ROUNDS) nxt = round64(nxt);
			end
		end else begin
			s = mix_state[7:0];
			if (b == 8'd0) begin
				v = 8'd0;
			end else begin
				law = (s ^ (b << 1)) & 8'h03;
				proj = (rotl8(s, 1) ^ b ^ {5'd0, b7} ^ {3'd0, b8, 2'b00}) & 8'h0C;
				v = law | proj | (b & 8'h80);
			end
			if (folding) begin
				repeat (FOLD_ROUNDS) v = round8(v, base_reg[7:0]);
			end
			nxt = {56'd0, v};
		end
		s8 = nxt[7:0];
		r.board = '0;
		if (rule_sel) begin
			r.win = {2'b00, nxt[mix_tick[5:0]]};
			off = int'(((mix_tick % 15) * 4 + nxt[3:0]) % BOARD_SLOTS);
			// the 60 bits land on distinct slots, so no write overwrites another
			for (int i = 0; i < 60; i++) begin
				r.board[(off + i) % BOARD_SLOTS] = nxt[i];
			end
		end else begin
			r.win = (((mix_tick / 7) & 64'd1) != 0) ? LINE_THIRD[b7] : LINE_FIRST[b7];
			off = (8 * int'(b7) + int'(s8[2:0])) % BOARD_SLOTS;
			for (int i = 0; i < 8; i++) begin
				if (s8[i]) begin
					r.board[(off + i) % BOARD_SLOTS] = 1'b1;
				end
			end
		end
		r.tick    = mix_tick;
		r.prev    = mix_state;
		r.curr    = nxt;
		r.mod7    = b7;
		r.mod8    = b8;
		r.law     = s8[1:0];
		r.edit    = s8[3:0] & 4'hC;
		r.bnd     = s8[7];
		r.braille = BRAILLE_BASE + {6'd0, s8};
		return r;
	endfunction

	task automatic check_field(input string name, input logic [63:0] exp_v,
		input logic [63:0] act_v);
		if (exp_v !== act_v) begin
			mismatch_count++;
			$display("%0t ns: %s mismatch, expected %h, got %h", $time, name, exp_v, act_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rule_sel = 1'b0;
			seed_reg = '0;
			base_reg = '0;
			mix_state = '0;
			mix_tick = '0;
			pending_steps.delete();
			mismatch_count = 0;
			steps_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[ADDR_W-1:3]))
					REG_RULE_SEL: rule_sel = pwdata[0];
					REG_START_SEED: seed_reg = pwdata;
					REG_BASE_CONSTANT: base_reg = pwdata;
					default: ;
				endcase
				if (reg_idx_t'(paddr[ADDR_W-1:3]) != REG_NONE) begin
					mix_tick = '0;
					mix_state = rule_sel ? seed_reg : base_reg;
				end
			end
			if (req_valid && !req_stall) begin
				want = mix_byte(input_byte);
				pending_steps.push_back(want);
				mix_state = want.curr;
				mix_tick = mix_tick + 64'd1;
			end
			if (res_valid && !res_stall) begin
				if (pending_steps.size() == 0) begin
					mismatch_count++;
					$display("%0t ns: result with no request waiting, expected none, got tick %h",
						$time, tick_value);
				end else begin
					want = pending_steps.pop_front();
					got.tick    = tick_value;
					got.prev    = old_state;
					got.curr    = new_state;
					got.mod7    = basis_seven;
					got.mod8    = basis_eight;
					got.law     = law_bits;
					got.edit    = edit_bits;
					got.bnd     = boundary;
					got.win     = winner;
					got.braille = braille_code;
					got.board   = board_bits;
					check_field("tick_value", want.tick, got.tick);
					check_field("old_state", want.prev, got.prev);
					check_field("new_state", want.curr, got.curr);
					check_field("basis_seven", 64'(want.mod7), 64'(got.mod7));
					check_field("basis_eight", 64'(want.mod8), 64'(got.mod8));
					check_field("law_bits", 64'(want.law), 64'(got.law));
					check_field("edit_bits", 64'(want.edit), 64'(got.edit));
					check_field("boundary", 64'(want.bnd), 64'(got.bnd));
					check_field("winner", 64'(want.win), 64'(got.win));
					check_field("braille_code", 64'(want.braille), 64'(got.braille));
					check_field("board_bits", want.board, got.board);
				end
			end
			steps_pending <= pending_steps.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives the state mixer with directed and random bytes under several register
// settings, with random gaps on requests and random result stalls; the checker
// beside the block predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------

module tb;
	import bdsm_pkg::*;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               req_valid = 1'b0;
	logic               req_stall;
	logic [7:0]         input_byte = 8'd0;
	logic               res_valid;
	logic               res_stall = 1'b0;
	logic [63:0]        tick_value;
	logic [63:0]        old_state;
	logic [63:0]        new_state;
	logic [2:0]         basis_seven;
	logic [2:0]         basis_eight;
	logic [1:0]         law_bits;
	logic [3:0]         edit_bits;
	logic               boundary;
	logic [2:0]         winner;
	logic [13:0]        braille_code;
	logic [63:0]        board_bits;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [ADDR_W-1:0]  paddr = '0;
	logic [63:0]        pwdata = '0;
	logic [63:0]        prdata;
	logic               pready;
	int unsigned        mismatch_count;
	int unsigned        steps_pending;

	// no idling on either side while set
	logic steady = 1'b0;
	int   stall_hold = 0;

	byte_driven_state_mixer_core dut (.*);

	bdsm_checker u_checker (.*);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 6) return 8'h00;
		if (r < 10) return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	always @(negedge clk) begin
		if (steady) begin
			res_stall = 1'b0;
			stall_hold = 0;
		end else if (stall_hold > 0) begin
			stall_hold--;
		end else begin
			res_stall = ($urandom_range(0, 99) < 35);
			stall_hold = gap_len();
		end
	end

	// called at a falling edge, returns at the falling edge after the accept
	task automatic send_byte(input logic [7:0] b);
		int n;
		n = steady ? 0 : gap_len();
		if (n > 0) begin
			req_valid = 1'b0;
			repeat (n) @(negedge clk);
		end
		req_valid = 1'b1;
		input_byte = b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		req_valid = 1'b0;
		while (steps_pending != 0) @(negedge clk);
	endtask

	task automatic reg_write(input reg_idx_t idx, input logic [63:0] val);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 3'b000};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] dir_reset [9];
		logic [7:0] dir_ones [4];
		logic [7:0] dir_seed [4];
		logic [7:0] dir_zero [3];
		int phase_len [6];
		logic rv;
		logic [63:0] sd;
		logic [63:0] bc;
		int burst_at;
		dir_reset = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'h7F, 8'h00, 8'hAA, 8'h55, 8'h03};
		dir_ones  = '{8'hFE, 8'h00, 8'h81, 8'h40};
		dir_seed  = '{8'h00, 8'hFF, 8'h01, 8'h80};
		dir_zero  = '{8'h00, 8'h00, 8'hFF};
		phase_len = '{120, 130, 200, 120, 90, 100};

		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// rule one from reset, zero bytes clear, ticks run past one week
		foreach (dir_reset[i]) send_byte(dir_reset[i]);
		wait_idle();
		reg_write(REG_BASE_CONSTANT, '1);
		foreach (dir_ones[i]) send_byte(dir_ones[i]);
		wait_idle();
		reg_write(REG_RULE_SEL, 64'd1);
		reg_write(REG_START_SEED, '1);
		foreach (dir_seed[i]) send_byte(dir_seed[i]);
		wait_idle();
		reg_write(REG_START_SEED, '0);
		foreach (dir_zero[i]) send_byte(dir_zero[i]);
		wait_idle();
		// unmapped register must leave state and tick alone
		reg_write(REG_NONE, {$urandom, $urandom});
		send_byte(8'h5A);
		send_byte(8'hA5);

		for (int ph = 0; ph < 6; ph++) begin
			wait_idle();
			case (ph)
				0: begin rv = 1'b0; sd = {$urandom, $urandom}; bc = '0; end
				1: begin rv = 1'b0; sd = {$urandom, $urandom}; bc = '1; end
				2: begin rv = 1'b1; sd = '0; bc = {$urandom, $urandom}; end
				3: begin rv = 1'b1; sd = '1; bc = {$urandom, $urandom}; end
				default: begin
					rv = 1'($urandom_range(0, 1));
					sd = {$urandom, $urandom};
					bc = {$urandom, $urandom};
				end
			endcase
			reg_write(REG_BASE_CONSTANT, bc);
			reg_write(REG_START_SEED, sd);
			reg_write(REG_RULE_SEL, {63'd0, rv});
			if (ph == 4) begin
				reg_write(REG_NONE, {$urandom, $urandom});
			end
			burst_at = $urandom_range(0, phase_len[ph] - 40);
			for (int i = 0; i < phase_len[ph]; i++) begin
				steady = (i >= burst_at) && (i < burst_at + 30);
				send_byte(rand_byte());
			end
			steady = 1'b0;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && steps_pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin : watchdog
		#10_000_000;
		$display("Some tests failed");
		$finish;
	end

endmodule
